// ----- hw/rtl/afa_pkg.sv -----
// Shared constants and types for the ADC frame averager.
`default_nettype none
package afa_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int POS_W      = 10;
   localparam int FRAMES_W   = 12;
   localparam int SPF_W      = 11;
   localparam int FTA_W      = 13;
   localparam int SUM_W      = 24;
   localparam int DIV_STEPS  = SUM_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
   localparam logic [FTA_W-1:0]    COUNT_MAX  = FTA_W'(4096);
   localparam logic [SPF_W-1:0]    SPF_RESET  = SPF_W'(625);
   localparam logic [FTA_W-1:0]    FTA_RESET  = FTA_W'(1000);

   // Register index, taken from paddr[2]
   typedef enum logic {
      CSR_SAMPLES_PER_FRAME = 1'b0,
      CSR_FRAMES_TO_AVERAGE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [FTA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic [SUM_W-1:0] quotient;
   } div_sts_type;

endpackage
`default_nettype wire

// ----- hw/rtl/afa_if.sv -----
// Request and response channel interfaces of the ADC frame averager.
`default_nettype none
interface afa_req_if;
   logic                          valid;
   logic                          ready;
   logic [afa_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface afa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [afa_pkg::SAMPLE_W-1:0]  average;
   logic [afa_pkg::POS_W-1:0]     position;
   logic                          frame_last;

   modport source (output valid, output average, output position, output frame_last,
                   input ready);
   modport sink   (input valid, input average, input position, input frame_last,
                   output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/afa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module afa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/afa_div.sv -----
// Radix-2 restoring divider: sum / frame count, one quotient bit per cycle.
`default_nettype none
module afa_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire afa_pkg::div_req_type req,
   output      afa_pkg::div_sts_type sts
);
   import afa_pkg::*;

   logic                  busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [FTA_W-1:0]      rem_ff, rem_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [FTA_W-1:0]      den_ff, den_in;
   logic [FTA_W:0]        trial;
   logic                  fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits FTA_W bits
         rem_in = fits ? FTA_W'(trial - {1'b0, den_ff}) : trial[FTA_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.quotient = quo_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/adc_frame_averager.sv -----
// Top level of the ADC frame averager: position accumulators, averaging and CSRs.
//
//  channel   direction  handshake          payload
//  req_bus   in         valid/ready        sample[11:0]
//  rsp_bus   out        valid/ready        average[11:0], position[9:0], frame_last
//  apb       in/out     psel/penable/pwrite paddr[2:0], pwdata/prdata[31:0]
//
// A sample outside the final frame of a run passes through accept (ST_IDLE) and the
// accumulator read-modify-write (ST_UPDATE) through the single-read-port sum RAM.
// A sample in the final frame then waits in ST_DIVIDE for the bit-serial divider.
// After reset the sum RAM is cleared one entry a cycle, all MAX_FRAME_LEN entries,
// with req ready low; CSR writes are taken throughout.
// A stalled response holds in the output register while the next request is taken.
`default_nettype none
module adc_frame_averager #(
   parameter int MAX_FRAME_LEN = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output      logic [31:0]          prdata,
   output      logic                 pready,
   afa_req_if.sink                   req_bus,
   afa_rsp_if.source                 rsp_bus
);
   import afa_pkg::*;

   localparam int AW = $clog2(MAX_FRAME_LEN);
   localparam int LEN_W = ($clog2(MAX_FRAME_LEN + 1) > SPF_W) ?
                          $clog2(MAX_FRAME_LEN + 1) : SPF_W;
   localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_FRAME_LEN);
   localparam logic [AW-1:0]    CLR_LAST = AW'(MAX_FRAME_LEN - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [SPF_W-1:0]       spf_ff, spf_in;
   logic [FTA_W-1:0]       fta_ff, fta_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [FRAMES_W-1:0]    frames_ff, frames_in;

   // request in flight
   logic [SAMPLE_W-1:0]    smp_ff, smp_in;
   logic [POS_W-1:0]       item_pos_ff, item_pos_in;
   logic                   item_last_ff, item_last_in;
   logic                   item_final_ff, item_final_in;
   logic [FTA_W-1:0]       item_cnt_ff, item_cnt_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]    rsp_avg_ff, rsp_avg_in;
   logic [POS_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [LEN_W-1:0]       eff_len;
   logic [FTA_W-1:0]       eff_cnt;
   logic                   last_pos;
   logic                   final_frame;
   logic                   accept;
   logic                   slot_free;
   logic                   csr_wr;
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       sum_sat;
   logic [SAMPLE_W-1:0]    avg_sat;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [SUM_W-1:0]       ram_wr_data;
   logic [SUM_W-1:0]       ram_rd_data;

   div_req_type            div_req;
   div_sts_type            div_sts;

   afa_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_FRAME_LEN)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (AW'(pos_ff)),
      .rd_data (ram_rd_data)
   );

   afa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .sts   (div_sts)
   );

   assign pready        = 1'b1;
   assign csr_wr        = psel && penable && pwrite && pready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      case (csr_index_type'(paddr[2]))
         CSR_SAMPLES_PER_FRAME: prdata = 32'(spf_ff);
         CSR_FRAMES_TO_AVERAGE: prdata = 32'(fta_ff);
         default:               prdata = '0;
      endcase
   end

   // effective frame length and frame count, with out-of-range values clamped
   always_comb begin
      eff_len = LEN_W'(spf_ff);
      if (spf_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (LEN_W'(spf_ff) > LEN_MAX) begin
         eff_len = LEN_MAX;
      end
      eff_cnt = fta_ff;
      if (fta_ff == '0) begin
         eff_cnt = FTA_W'(1);
      end else if (fta_ff > COUNT_MAX) begin
         eff_cnt = COUNT_MAX;
      end
      last_pos    = (LEN_W'(pos_ff) + LEN_W'(1)) >= eff_len;
      final_frame = ({1'b0, frames_ff} + FTA_W'(1)) >= eff_cnt;
   end

   always_comb begin
      sum_wide = {1'b0, ram_rd_data} + (SUM_W + 1)'(smp_ff);
      sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      avg_sat  = (div_sts.quotient > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX :
                 div_sts.quotient[SAMPLE_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      spf_in        = spf_ff;
      fta_in        = fta_ff;
      pos_in        = pos_ff;
      frames_in     = frames_ff;
      smp_in        = smp_ff;
      item_pos_in   = item_pos_ff;
      item_last_in  = item_last_ff;
      item_final_in = item_final_ff;
      item_cnt_in   = item_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = AW'(item_pos_ff);
      ram_wr_data   = '0;
      div_req.start    = 1'b0;
      div_req.dividend = sum_sat;
      div_req.divisor  = item_cnt_ff;

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr) begin
         case (csr_index_type'(paddr[2]))
            CSR_SAMPLES_PER_FRAME: spf_in = pwdata[SPF_W-1:0];
            CSR_FRAMES_TO_AVERAGE: fta_in = pwdata[FTA_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            clr_cnt_in  = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               smp_in        = req_bus.sample;
               item_pos_in   = pos_ff;
               item_last_in  = last_pos;
               item_final_in = final_frame;
               item_cnt_in   = eff_cnt;
               if (last_pos) begin
                  pos_in    = '0;
                  frames_in = final_frame ? '0 : frames_ff + FRAMES_W'(1);
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // final frame: entry goes back to zero and the sum is divided
            ram_wr_en   = 1'b1;
            ram_wr_data = item_final_ff ? '0 : sum_sat;
            if (item_final_ff) begin
               div_req.start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (!div_sts.busy && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = avg_sat;
               rsp_pos_in   = item_pos_ff;
               rsp_last_in  = item_last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         spf_ff       <= SPF_RESET;
         fta_ff       <= FTA_RESET;
         pos_ff       <= '0;
         frames_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         spf_ff       <= spf_in;
         fta_ff       <= fta_in;
         pos_ff       <= pos_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      smp_ff        <= smp_in;
      item_pos_ff   <= item_pos_in;
      item_last_ff  <= item_last_in;
      item_final_ff <= item_final_in;
      item_cnt_ff   <= item_cnt_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.average    = rsp_avg_ff;
   assign rsp_bus.position   = rsp_pos_ff;
   assign rsp_bus.frame_last = rsp_last_ff;

endmodule
`default_nettype wire

// ----- test/afa_checker.sv -----
// Watches the sample and average channels, predicts each averaged value and compares.
`default_nettype none
module afa_checker #(
   parameter int MAX_LEN = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic        pready,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   afa_req_if               req_mon,
   afa_rsp_if               rsp_mon,
   output int               fail_count,
   output int               pending,
   output int               averages_checked
);
   import afa_pkg::*;

   typedef struct packed {
      logic [SAMPLE_W-1:0] average;
      logic [POS_W-1:0]    position;
      logic                frame_last;
   } avg_result_type;

   logic [SUM_W-1:0]    sum_mem [MAX_LEN];
   logic [POS_W-1:0]    cur_pos;
   logic [FRAMES_W-1:0] frames_done;
   logic [SPF_W-1:0]    frame_len;
   logic [FTA_W-1:0]    run_frames;
   avg_result_type      expected_averages [$];
   avg_result_type      got;
   avg_result_type      want;

   // Adds one sample into its position; in the final frame of a run it queues
   // the average for that position and clears the entry instead.
   function automatic void fold_sample(input logic [SAMPLE_W-1:0] s);
      int unsigned    len;
      int unsigned    cnt;
      int unsigned    acc;
      int unsigned    quo;
      logic           at_frame_end;
      logic           in_final_frame;
      avg_result_type r;
      len = (frame_len == '0) ? 1 : ((frame_len > MAX_LEN) ? MAX_LEN : frame_len);
      cnt = (run_frames == '0) ? 1 : ((run_frames > COUNT_MAX) ? COUNT_MAX : run_frames);
      at_frame_end = (int'(cur_pos) + 1) >= len;
      in_final_frame = (int'(frames_done) + 1) >= cnt;
      acc = sum_mem[cur_pos] + s;
      if (acc > SUM_MAX) acc = SUM_MAX;
      if (in_final_frame) begin
         quo = acc / cnt;
         // only reachable after the count or the frame length was changed mid-run
         if (quo > SAMPLE_MAX) quo = SAMPLE_MAX;
         r.average = SAMPLE_W'(quo);
         r.position = cur_pos;
         r.frame_last = at_frame_end;
         expected_averages.push_back(r);
         sum_mem[cur_pos] = '0;
      end else begin
         sum_mem[cur_pos] = SUM_W'(acc);
      end
      if (at_frame_end) begin
         cur_pos = '0;
         frames_done = in_final_frame ? '0 : frames_done + 1'b1;
      end else begin
         cur_pos = cur_pos + 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LEN; i++) sum_mem[i] = '0;
         cur_pos = '0;
         frames_done = '0;
         frame_len = SPF_RESET;
         run_frames = FTA_RESET;
         expected_averages.delete();
         fail_count = 0;
         averages_checked = 0;
      end else begin
         // a request taken at this edge still sees the old register values
         if (req_mon.valid && req_mon.ready) fold_sample(req_mon.sample);
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[2]))
               CSR_SAMPLES_PER_FRAME: frame_len = pwdata[SPF_W-1:0];
               CSR_FRAMES_TO_AVERAGE: run_frames = pwdata[FTA_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.average = rsp_mon.average;
            got.position = rsp_mon.position;
            got.frame_last = rsp_mon.frame_last;
            if (expected_averages.size() == 0) begin
               fail_count++;
               $display("%0t: average %0d at position %0d (last %0b) with none expected",
                        $time, got.average, got.position, got.frame_last);
            end else begin
               want = expected_averages.pop_front();
               averages_checked++;
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: expected average %0d position %0d last %0b, got %0d %0d %0b",
                           $time, want.average, want.position, want.frame_last,
                           got.average, got.position, got.frame_last);
               end
            end
         end
      end
      pending = expected_averages.size();
   end

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Stimulus and verdict for the ADC frame averager, with the checker beside it.
`default_nettype none
module tb_top;
   import afa_pkg::*;

   localparam int MAX_LEN      = 1024;
   localparam int DRAIN_CYCLES = 40;    // final-frame sample: accept, RMW, 24-step divide
   localparam int LONG_HOLD    = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic        pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   int          fail_count;
   int          pending;
   int          averages_checked;
   int          samples_sent = 0;
   int          settings_used = 0;
   int          req_gap_max = 3;
   int          rsp_gap_max = 3;
   bit          hold_rsp = 1'b0;

   afa_req_if req_bus();
   afa_rsp_if rsp_bus();

   adc_frame_averager #(.MAX_FRAME_LEN(MAX_LEN)) u_top (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   afa_checker #(.MAX_LEN(MAX_LEN)) u_checker (
      .clock, .reset, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .req_mon(req_bus),
      .rsp_mon(rsp_bus),
      .fail_count, .pending, .averages_checked
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   // response side: random stalls, plus one long hold on request
   initial begin : rsp_side
      int gap;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
         end
         gap = $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.sample <= s;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      @(negedge clock);
      samples_sent++;
   endtask

   task automatic send_random_sample();
      logic [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 9))
         0:       s = '0;
         1:       s = SAMPLE_MAX;
         default: s = SAMPLE_W'($urandom_range(0, 4095));
      endcase
      send_sample(s);
   endtask

   // stop offering samples and let every pending average come out
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [31:0] spf, input logic [31:0] fta);
      wait_idle();
      csr_write(CSR_SAMPLES_PER_FRAME, spf);
      csr_write(CSR_FRAMES_TO_AVERAGE, fta);
      settings_used++;
   endtask

   initial begin : stimulus
      int round;
      int random_base;
      logic [31:0] spf;
      logic [31:0] fta;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // reset settings: these only accumulate
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample(12'hAAA);
      send_sample(12'h555);

      // zero length and zero count act as one: every sample averages alone,
      // starting mid-frame; position 0 then holds 4095 + sample and clips
      set_config(0, 0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      send_sample(12'd1);
      send_sample(12'h800);

      set_config(2, 3);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);

      // oversize length clamps to the full frame; output backs up into the input
      set_config(32'h7FF, 1);
      hold_rsp = 1'b1;
      repeat (120) send_random_sample();

      // full-scale partial run, then the count drops to one: the quotient
      // of the stored sums overflows the sample range and clips
      set_config(2, 8);
      req_gap_max = 0;
      repeat (14) send_sample(SAMPLE_MAX);
      req_gap_max = 3;
      set_config(2, 1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);

      // random settings, changed without regard to frame boundaries
      random_base = averages_checked;
      round = 0;
      while ((round < 10 || averages_checked - random_base < 60) && round < 14) begin
         case ($urandom_range(0, 9))
            0:       spf = 0;
            1:       spf = 32'h7FF;
            2:       spf = $urandom_range(9, 40);
            default: spf = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 9))
            0:       fta = 0;
            1:       fta = 32'h1FFF;
            2:       fta = COUNT_MAX;
            default: fta = $urandom_range(1, 8);
         endcase
         set_config(spf, fta);
         req_gap_max = (round % 3 == 0) ? 0 : 3;
         rsp_gap_max = (round % 4 == 1) ? 0 : 3;
         repeat (30) send_random_sample();
         round++;
      end

      wait_idle();
      $display("%0d samples sent, %0d averages checked, %0d register settings",
               samples_sent, averages_checked, settings_used);
      $display("covered zero and oversize settings, mid-run changes, long output stall,");
      $display("average saturation after a lowered count");
      if (fail_count == 0 && pending == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/afa_pkg.sv
hw/rtl/afa_if.sv
hw/rtl/afa_ram.sv
hw/rtl/afa_div.sv
hw/rtl/adc_frame_averager.sv
test/afa_checker.sv
test/tb_top.sv
